>>> rtl/core/binary_heap_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Binary heap priority queue assertion macros
// Shared property templates for the checker, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binary heap queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define BHPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binary heap queue check failed");

`endif

>>> rtl/core/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Transaction types, operation and status codes shared by the block's files.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int KEY_FIELD_W   = 32;
    localparam int COUNT_FIELD_W = 11;
    localparam int CMD_QUEUE_DEPTH    = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_POP,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]                     op;
        logic signed [KEY_FIELD_W-1:0]  key_value;
    } request_t;

    typedef struct packed {
        logic signed [KEY_FIELD_W-1:0]  popped_value;
        logic [1:0]                     status;
        logic signed [KEY_FIELD_W-1:0]  top_value;
        logic                           top_valid;
        logic [COUNT_FIELD_W-1:0]       element_count;
    } response_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [KEY_FIELD_W-1:0] key;
    } cmd_t;

endpackage

>>> rtl/core/bhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/bhpq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small register queue
// Holds a few transactions so that producer and consumer stall independently.
// ----------------------------------------------------------------------------
module bhpq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [LW-1:0]    level_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                slots_reg[wr_ptr_reg] <= wdata;
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + LW'(1);
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - LW'(1);
            end
        end
    end

endmodule

>>> rtl/core/bhpq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue front end
// Accepts request transactions, decodes the operation and queues commands.
// ----------------------------------------------------------------------------
module bhpq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bhpq_pkg::request_t request,
    output logic              full,
    output logic              cmd_valid,
    output bhpq_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);

    import bhpq_pkg::*;

    cmd_t decoded;
    logic cmd_empty;

    always_comb
    begin
        decoded.key = request.key_value;
        unique case (request.op)
            OP_PUSH:  decoded.kind = CMD_PUSH;
            OP_POP:   decoded.kind = CMD_POP;
            OP_CLEAR: decoded.kind = CMD_CLEAR;
            default:  decoded.kind = CMD_NOP;
        endcase
    end

    bhpq_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (decoded),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

>>> rtl/core/bhpq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue engine
// Executes queued commands on the heap RAM with hole-based sift up and down.
// ----------------------------------------------------------------------------
module bhpq_engine #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               heap_mode,
    input  logic               cmd_valid,
    input  bhpq_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    input  logic               res_full,
    output logic               res_push,
    output bhpq_pkg::response_t res
);

    import bhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST_RD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } state_t;

    function automatic logic better(input logic mode, input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b);
        return mode ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
    endfunction

    state_t               state_reg,  state_next;
    logic [CW-1:0]        count_reg,  count_next;
    logic [KEY_WIDTH-1:0] top_reg,    top_next;
    logic [KEY_WIDTH-1:0] cur_reg,    cur_next;
    logic [KEY_WIDTH-1:0] left_reg,   left_next;
    logic [KEY_WIDTH-1:0] popped_reg, popped_next;
    logic [AW-1:0]        pos_reg,    pos_next;
    logic [1:0]           status_reg, status_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic [AW-1:0]        parent;
    logic [LW-1:0]        lc;
    logic [LW-1:0]        rc;
    logic                 rc_ok;
    logic                 take_right;
    logic [KEY_WIDTH-1:0] pick_val;
    logic [AW-1:0]        pick_addr;

    assign parent     = (pos_reg - AW'(1)) >> 1;
    assign lc         = {1'b0, pos_reg, 1'b1};
    assign rc         = lc + LW'(1);
    assign rc_ok      = rc < LW'(count_reg);
    assign take_right = rc_ok && better(heap_mode, ram_rdata, left_reg);
    assign pick_val   = take_right ? ram_rdata : left_reg;
    assign pick_addr  = take_right ? rc[AW-1:0] : lc[AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        popped_next = popped_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = cur_reg;
        ram_re      = 1'b0;
        ram_raddr   = parent;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    status_next = STATUS_OK;
                    popped_next = '0;
                    unique case (cmd.kind)
                        CMD_PUSH:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                cur_next   = KEY_WIDTH'(cmd.key);
                                pos_next   = AW'(count_reg);
                                count_next = count_reg + CW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                popped_next = top_reg;
                                count_next  = count_reg - CW'(1);
                                pos_next    = '0;
                                if (count_reg == CW'(1))
                                begin
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = AW'(count_reg - CW'(1));
                                    state_next = S_LAST_RD;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LAST_RD:
            begin
                cur_next   = ram_rdata;
                state_next = S_DN_RDL;
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (better(heap_mode, cur_reg, ram_rdata))
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DN_RDL:
            begin
                if (lc >= LW'(count_reg))
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = lc[AW-1:0];
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR:
            begin
                left_next  = ram_rdata;
                ram_re     = rc_ok;
                ram_raddr  = rc[AW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (better(heap_mode, pick_val, cur_reg))
                begin
                    ram_wdata  = pick_val;
                    pos_next   = pick_addr;
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        top_next = top_reg;
        if (ram_we && ram_waddr == '0)
        begin
            top_next = ram_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            top_reg    <= '0;
            cur_reg    <= '0;
            left_reg   <= '0;
            popped_reg <= '0;
            pos_reg    <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            cur_reg    <= cur_next;
            left_reg   <= left_next;
            popped_reg <= popped_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    bhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        res.popped_value  = KEY_FIELD_W'(popped_reg);
        res.status        = status_reg;
        res.top_value     = (count_reg != '0) ? KEY_FIELD_W'(top_reg) : '0;
        res.top_valid     = (count_reg != '0);
        res.element_count = COUNT_FIELD_W'(count_reg);
    end

endmodule

>>> rtl/core/binary_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// Clear, no-op, pop on empty and push on full go from accept straight to the result.
// A push reads a parent and compares per level it rises, up to log2(CAPACITY) levels.
// A pop reads the last key, then reads children and compares, up to log2(CAPACITY) levels.
// The single read port of the heap RAM sets the cost of every sift level.
// The engine runs one transaction at a time and takes the next once its result is queued.
// Reset empties the heap and the queues at once; RAM contents stay as they were.
// ----------------------------------------------------------------------------
// Binary heap priority queue unit
// Max or min heap with push, pop and clear, queued on both sides.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  bhpq_pkg::request_t  request,
    output logic                empty,
    input  logic                pop,
    output bhpq_pkg::response_t response,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    import bhpq_pkg::*;

    logic      heap_mode_reg;
    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_pop;
    logic      res_full;
    logic      res_push;
    response_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            heap_mode_reg <= cfg_wdata;
        end
    end

    bhpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    bhpq_engine #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .heap_mode (heap_mode_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    bhpq_fifo #(
        .WIDTH ($bits(response_t)),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (response),
        .empty (empty)
    );

endmodule

>>> rtl/core/bhpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_heap_priority_queue_unit_assert.svh"

module bhpq_checker #(
    parameter int CAPACITY = 1024
) (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input bhpq_pkg::response_t response
);

    import bhpq_pkg::*;

    `BHPQ_ASSERT_NOW(a_valid_matches_count, !empty, response.top_valid == (response.element_count != '0))
    `BHPQ_ASSERT_NOW(a_top_zero_when_empty, !empty && !response.top_valid, response.top_value == '0)
    `BHPQ_ASSERT_NOW(a_empty_pop_status, !empty && response.status == STATUS_EMPTY, response.popped_value == '0 && response.element_count == '0)
    `BHPQ_ASSERT_NOW(a_full_push_status, !empty && response.status == STATUS_FULL, response.element_count == COUNT_FIELD_W'(CAPACITY))
    `BHPQ_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(response))

endmodule

bind binary_heap_priority_queue_unit bhpq_checker #(
    .CAPACITY (CAPACITY)
) u_bhpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .response (response)
);
